>>> src/mbsp_pkg.sv
package mbsp_pkg;

    localparam int SIZE_BITS = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } mbsp_in_t;

    typedef struct packed {
        logic [3:0]  field_id;
        logic [31:0] box_type;
        logic [1:0]  nest_level;
        logic [63:0] field_value;
    } mbsp_out_t;

    typedef enum logic [6:0] {
        PH_HDR    = 7'b0000001,
        PH_MAJOR  = 7'b0000010,
        PH_MINOR  = 7'b0000100,
        PH_COMPAT = 7'b0001000,
        PH_MVHD   = 7'b0010000,
        PH_TKHD   = 7'b0100000,
        PH_SKIP   = 7'b1000000
    } phase_t;

    localparam logic [31:0] T_FTYP = 32'h66747970;
    localparam logic [31:0] T_MOOV = 32'h6D6F6F76;
    localparam logic [31:0] T_MVHD = 32'h6D766864;
    localparam logic [31:0] T_TRAK = 32'h7472616B;
    localparam logic [31:0] T_TKHD = 32'h746B6864;
    localparam logic [31:0] T_MDAT = 32'h6D646174;
    localparam logic [31:0] T_FREE = 32'h66726565;

    localparam logic [3:0] ID_HDR    = 4'd0;
    localparam logic [3:0] ID_MAJOR  = 4'd1;
    localparam logic [3:0] ID_MINOR  = 4'd2;
    localparam logic [3:0] ID_COMPAT = 4'd3;
    localparam logic [3:0] ID_VFLAGS = 4'd4;
    localparam logic [3:0] ID_CTIME  = 4'd5;
    localparam logic [3:0] ID_MTIME  = 4'd6;
    localparam logic [3:0] ID_TSCALE = 4'd7;
    localparam logic [3:0] ID_DUR    = 4'd8;
    localparam logic [3:0] ID_NEXT   = 4'd9;
    localparam logic [3:0] ID_TRACK  = 4'd10;
    localparam logic [3:0] ID_LAYER  = 4'd11;
    localparam logic [3:0] ID_WIDTH  = 4'd12;
    localparam logic [3:0] ID_HEIGHT = 4'd13;
    localparam logic [3:0] ID_ERR    = 4'd14;

    typedef struct packed {
        logic       hit;
        logic [3:0] id;
        logic [3:0] nbytes;
    } slot_t;

    function automatic logic [1:0] level_of(input logic [31:0] t);
        if (t == T_FTYP || t == T_MOOV) return 2'd0;
        if (t == T_TKHD) return 2'd2;
        return 2'd1;
    endfunction

    // field lookup by payload offset of the field's last byte
    function automatic slot_t slot_lookup(input logic is_mvhd, input logic lng,
                                          input logic [7:0] p);
        slot_t s;
        s = '{hit: 1'b0, id: ID_HDR, nbytes: 4'd4};
        if (is_mvhd && !lng) begin
            case (p)
                8'd7:    s = '{1'b1, ID_CTIME, 4'd4};
                8'd11:   s = '{1'b1, ID_MTIME, 4'd4};
                8'd15:   s = '{1'b1, ID_TSCALE, 4'd4};
                8'd19:   s = '{1'b1, ID_DUR, 4'd4};
                8'd99:   s = '{1'b1, ID_NEXT, 4'd4};
                default: s.hit = 1'b0;
            endcase
        end else if (is_mvhd) begin
            case (p)
                8'd11:   s = '{1'b1, ID_CTIME, 4'd8};
                8'd19:   s = '{1'b1, ID_MTIME, 4'd8};
                8'd23:   s = '{1'b1, ID_TSCALE, 4'd4};
                8'd31:   s = '{1'b1, ID_DUR, 4'd8};
                8'd111:  s = '{1'b1, ID_NEXT, 4'd4};
                default: s.hit = 1'b0;
            endcase
        end else if (!lng) begin
            case (p)
                8'd7:    s = '{1'b1, ID_CTIME, 4'd4};
                8'd11:   s = '{1'b1, ID_MTIME, 4'd4};
                8'd15:   s = '{1'b1, ID_TRACK, 4'd4};
                8'd23:   s = '{1'b1, ID_DUR, 4'd4};
                8'd33:   s = '{1'b1, ID_LAYER, 4'd2};
                8'd79:   s = '{1'b1, ID_WIDTH, 4'd4};
                8'd83:   s = '{1'b1, ID_HEIGHT, 4'd4};
                default: s.hit = 1'b0;
            endcase
        end else begin
            case (p)
                8'd11:   s = '{1'b1, ID_CTIME, 4'd8};
                8'd19:   s = '{1'b1, ID_MTIME, 4'd8};
                8'd23:   s = '{1'b1, ID_TRACK, 4'd4};
                8'd35:   s = '{1'b1, ID_DUR, 4'd8};
                8'd45:   s = '{1'b1, ID_LAYER, 4'd2};
                8'd91:   s = '{1'b1, ID_WIDTH, 4'd4};
                8'd95:   s = '{1'b1, ID_HEIGHT, 4'd4};
                default: s.hit = 1'b0;
            endcase
        end
        return s;
    endfunction

endpackage

>>> src/mbsp_parse.sv
module mbsp_parse
    import mbsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  mbsp_in_t  in_item,
    output logic      res_valid,
    output mbsp_out_t res_item
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [31:0] left_reg, left_next;
    logic [63:0] acc_reg;
    logic [31:0] type_reg, type_next;
    logic        long_reg, long_next;
    logic        first_reg, first_next;
    logic        halt_reg, halt_next;

    // state as seen after an optional restart
    phase_t      ph;
    logic [7:0]  pos;
    logic [31:0] left;
    logic [63:0] acc_in, acc_new;
    logic        lng, first, halt;

    logic [31:0] hdr_type;
    logic [SIZE_BITS-1:0] hdr_size;
    logic [31:0] size32, len32;
    logic [7:0]  pos_inc;
    logic [31:0] left_dec;
    logic [7:0]  total;
    slot_t       slot;
    logic [63:0] masked;

    always_comb begin
        ph    = in_item.file_start ? PH_HDR : phase_reg;
        pos   = in_item.file_start ? 8'd0 : pos_reg;
        left  = in_item.file_start ? 32'd0 : left_reg;
        acc_in = in_item.file_start ? 64'd0 : acc_reg;
        lng   = in_item.file_start ? 1'b0 : long_reg;
        first = in_item.file_start ? 1'b1 : first_reg;
        halt  = in_item.file_start ? 1'b0 : halt_reg;
        acc_new  = {acc_in[55:0], in_item.data_byte};
        hdr_type = acc_new[31:0];
        hdr_size = acc_new[32 +: SIZE_BITS];
        size32   = 32'(hdr_size);
        len32    = size32 - 32'd8;
        pos_inc  = pos + 8'd1;
        left_dec = (left != 32'd0) ? left - 32'd1 : 32'd0;
        total = (ph == PH_MVHD) ? (lng ? 8'd112 : 8'd100) : (lng ? 8'd96 : 8'd84);
        slot  = slot_lookup(ph == PH_MVHD, lng, pos);
        case (slot.nbytes)
            4'd2:    masked = {48'd0, acc_new[15:0]};
            4'd4:    masked = {32'd0, acc_new[31:0]};
            default: masked = acc_new;
        endcase
    end

    always_comb begin
        phase_next = ph;
        pos_next   = pos;
        left_next  = left;
        type_next  = in_item.file_start ? 32'd0 : type_reg;
        long_next  = lng;
        first_next = first;
        halt_next  = halt;
        res_valid  = 1'b0;
        res_item   = '{field_id: ID_HDR, box_type: type_reg, nest_level: 2'd0,
                       field_value: 64'd0};
        if (!halt) begin
            if (ph == PH_HDR) begin
                pos_next = pos_inc;
                if (pos_inc >= 8'd8) begin
                    pos_next  = 8'd0;
                    type_next = hdr_type;
                    res_item.box_type = hdr_type;
                    if (first && hdr_type != T_FTYP) begin
                        halt_next = 1'b1;
                    end else if (size32 < 32'd8 || (hdr_type == T_FTYP &&
                                 (len32 < 32'd8 || len32[1:0] != 2'd0))) begin
                        halt_next = 1'b1;
                        res_valid = 1'b1;
                        res_item.field_id    = ID_ERR;
                        res_item.field_value = {32'd0, size32};
                    end else begin
                        first_next = 1'b0;
                        left_next  = len32;
                        case (hdr_type)
                            T_FTYP:         phase_next = PH_MAJOR;
                            T_MOOV, T_TRAK: phase_next = PH_HDR;
                            T_MVHD: phase_next = (len32 != 32'd0) ? PH_MVHD : PH_HDR;
                            T_TKHD: phase_next = (len32 != 32'd0) ? PH_TKHD : PH_HDR;
                            default: phase_next = (len32 != 32'd0) ? PH_SKIP : PH_HDR;
                        endcase
                        if (hdr_type == T_FTYP || hdr_type == T_MOOV ||
                            hdr_type == T_MVHD || hdr_type == T_TRAK ||
                            hdr_type == T_TKHD || hdr_type == T_MDAT ||
                            hdr_type == T_FREE) begin
                            res_valid = 1'b1;
                            res_item.nest_level  = level_of(hdr_type);
                            res_item.field_value = {32'd0, len32};
                        end
                    end
                end
            end else begin
                left_next = left_dec;
                res_item.nest_level = level_of(type_reg);
                case (ph)
                    PH_MAJOR, PH_MINOR, PH_COMPAT: begin
                        res_item.nest_level = 2'd0;
                        pos_next = pos_inc;
                        if (pos_inc >= 8'd4) begin
                            pos_next  = 8'd0;
                            res_valid = 1'b1;
                            res_item.field_id = (ph == PH_MAJOR) ? ID_MAJOR :
                                                (ph == PH_MINOR) ? ID_MINOR : ID_COMPAT;
                            res_item.field_value = {32'd0, acc_new[31:0]};
                            if (ph == PH_MAJOR) phase_next = PH_MINOR;
                            else if (ph == PH_MINOR) phase_next = PH_COMPAT;
                        end
                    end
                    PH_MVHD, PH_TKHD: begin
                        pos_next = pos_inc;
                        if (pos == 8'd3) begin
                            long_next = acc_new[31:24] != 8'd0;
                            res_valid = 1'b1;
                            res_item.field_id    = ID_VFLAGS;
                            res_item.field_value = {32'd0, acc_new[31:0]};
                        end else begin
                            res_valid = slot.hit;
                            res_item.field_id    = slot.id;
                            res_item.field_value = masked;
                            if (pos_inc >= total) phase_next = PH_SKIP;
                        end
                    end
                    default: ;
                endcase
                if (left_dec == 32'd0) begin
                    phase_next = PH_HDR;
                    pos_next   = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            pos_reg   <= 8'd0;
            left_reg  <= 32'd0;
            acc_reg   <= 64'd0;
            type_reg  <= 32'd0;
            long_reg  <= 1'b0;
            first_reg <= 1'b1;
            halt_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            if (!halt) acc_reg <= acc_new;
            else acc_reg <= acc_in;
            type_reg  <= type_next;
            long_reg  <= long_next;
            first_reg <= first_next;
            halt_reg  <= halt_next;
        end
    end

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg)) else $error("phase not one-hot");
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (halt_reg && step && !in_item.file_start) |-> !res_valid)
        else $error("result while halted");
    a_hdr_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_MAJOR || phase_reg == PH_MINOR || phase_reg == PH_COMPAT)
        |-> pos_reg < 8'd4) else $error("byte position out of range");

endmodule

>>> src/mbsp_out_reg.sv
module mbsp_out_reg
    import mbsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  logic      res_valid,
    input  mbsp_out_t res_item,
    output logic      m_valid,
    input  logic      m_ready,
    output mbsp_out_t m_data
);

    logic      valid_reg;
    mbsp_out_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) data_reg <= res_item;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled item changed");

endmodule

>>> src/mp4_box_stream_parser_core.sv
// MP4 box stream parser.
// s_ channel: one file byte per item (s_data.data_byte); s_data.file_start
// marks the first byte of a file and restarts the parse.
// m_ channel: field records (id, box type, nesting level, value), at most one
// per input byte: headers, ftyp brands, mvhd/tkhd fields and error records.
// Throughput: one byte per cycle while no record waits unaccepted. The whole
// step for a byte is one pass of logic into the parser state and the result
// register. A record appears on m_ in the cycle after the byte that completes it.
// The single output register can be refilled in the same cycle it is drained,
// so a new byte is taken whenever the record slot is empty or being taken.
// Receiver stall: while a record waits unaccepted, s_ready is low.
// Reset (aresetn low, synchronous): expect a box header, first box pending,
// output empty.
module mp4_box_stream_parser_core
    import mbsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mbsp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mbsp_out_t m_data
);

    logic      step;
    logic      res_valid;
    mbsp_out_t res_item;

    assign s_ready = !m_valid || m_ready;
    assign step    = s_valid && s_ready;

    mbsp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    mbsp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step),
        .res_valid (res_valid),
        .res_item  (res_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> tb/sv/mbsp_checker.sv
`timescale 1ns / 100ps

module mbsp_checker
    import mbsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  mbsp_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  mbsp_out_t m_data,
    output int        errors,
    output int        waiting
);

    phase_t      ph;
    logic [7:0]  pos;
    logic [31:0] left;
    logic [63:0] acc;
    logic [31:0] cur_type;
    logic        long_t;
    logic        first_box;
    logic        stopped;

    mbsp_out_t   records_due[$];

    function automatic logic [1:0] nest_for(input logic [31:0] t);
        if (t == T_FTYP || t == T_MOOV) return 2'd0;
        if (t == T_TKHD) return 2'd2;
        return 2'd1;
    endfunction

    // field that ends at payload offset p; returns 0 where nothing ends
    function automatic logic field_at(input logic is_mvhd, input logic lng, input logic [7:0] p,
                                      output logic [3:0] id, output int nb);
        id = ID_HDR;
        nb = 4;
        case ({is_mvhd, lng})
            2'b10: case (p)
                7: id = ID_CTIME;   11: id = ID_MTIME;  15: id = ID_TSCALE;
                19: id = ID_DUR;    99: id = ID_NEXT;
                default: return 1'b0;
            endcase
            2'b11: case (p)
                11: begin id = ID_CTIME; nb = 8; end
                19: begin id = ID_MTIME; nb = 8; end
                23: id = ID_TSCALE;
                31: begin id = ID_DUR; nb = 8; end
                111: id = ID_NEXT;
                default: return 1'b0;
            endcase
            2'b00: case (p)
                7: id = ID_CTIME;   11: id = ID_MTIME;  15: id = ID_TRACK;
                23: id = ID_DUR;    33: begin id = ID_LAYER; nb = 2; end
                79: id = ID_WIDTH;  83: id = ID_HEIGHT;
                default: return 1'b0;
            endcase
            default: case (p)
                11: begin id = ID_CTIME; nb = 8; end
                19: begin id = ID_MTIME; nb = 8; end
                23: id = ID_TRACK;
                35: begin id = ID_DUR; nb = 8; end
                45: begin id = ID_LAYER; nb = 2; end
                91: id = ID_WIDTH;  95: id = ID_HEIGHT;
                default: return 1'b0;
            endcase
        endcase
        return 1'b1;
    endfunction

    task automatic add_record(input logic [3:0] id, input logic [31:0] t, input logic [1:0] lvl,
                              input logic [63:0] v);
        mbsp_out_t r;
        r.field_id = id;
        r.box_type = t;
        r.nest_level = lvl;
        r.field_value = v;
        records_due = {records_due, r};
    endtask

    task automatic restart_parse();
        ph = PH_HDR;
        pos = '0;
        left = '0;
        acc = '0;
        cur_type = '0;
        long_t = 1'b0;
        first_box = 1'b1;
        stopped = 1'b0;
    endtask

    task automatic take_header();
        logic [31:0] t;
        logic [63:0] sz;
        logic [31:0] len;
        t = acc[31:0];
        sz = (acc >> 32) & ((64'd1 << SIZE_BITS) - 1);
        cur_type = t;
        if (first_box && t != T_FTYP) begin
            stopped = 1'b1;
            return;
        end
        if (sz < 8) begin
            stopped = 1'b1;
            add_record(ID_ERR, t, 2'd0, sz);
            return;
        end
        len = sz[31:0] - 32'd8;
        if (t == T_FTYP && (len < 8 || len[1:0] != 2'b00)) begin
            stopped = 1'b1;
            add_record(ID_ERR, t, 2'd0, sz);
            return;
        end
        first_box = 1'b0;
        left = len;
        pos = '0;
        case (t)
            T_FTYP: ph = PH_MAJOR;
            T_MOOV, T_TRAK: ph = PH_HDR;
            T_MVHD: ph = (len != 0) ? PH_MVHD : PH_HDR;
            T_TKHD: ph = (len != 0) ? PH_TKHD : PH_HDR;
            default: ph = (len != 0) ? PH_SKIP : PH_HDR;
        endcase
        if (t inside {T_FTYP, T_MOOV, T_MVHD, T_TRAK, T_TKHD, T_MDAT, T_FREE})
            add_record(ID_HDR, t, nest_for(t), {32'd0, len});
    endtask

    task automatic decode_layout(input logic is_mvhd);
        logic [7:0] p;
        logic [3:0] id;
        int nb;
        int total;
        p = pos;
        pos = p + 8'd1;
        if (p == 8'd3) begin
            long_t = (acc[31:24] != 8'd0);
            add_record(ID_VFLAGS, cur_type, nest_for(cur_type), {32'd0, acc[31:0]});
            return;
        end
        if (field_at(is_mvhd, long_t, p, id, nb))
            add_record(id, cur_type, nest_for(cur_type),
                       (nb == 8) ? acc : acc & ((64'd1 << (nb * 8)) - 1));
        if (is_mvhd) total = long_t ? 112 : 100;
        else total = long_t ? 96 : 84;
        if (int'(p) + 1 >= total) ph = PH_SKIP;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fs);
        if (fs) restart_parse();
        if (stopped) return;
        acc = {acc[55:0], b};
        if (ph == PH_HDR) begin
            pos = pos + 8'd1;
            if (pos < 8) return;
            pos = '0;
            take_header();
            return;
        end
        if (left > 0) left = left - 1;
        case (ph)
            PH_MAJOR, PH_MINOR, PH_COMPAT: begin
                pos = pos + 8'd1;
                if (pos >= 4) begin
                    pos = '0;
                    add_record((ph == PH_MAJOR) ? ID_MAJOR : (ph == PH_MINOR) ? ID_MINOR
                               : ID_COMPAT, cur_type, 2'd0, {32'd0, acc[31:0]});
                    if (ph == PH_MAJOR) ph = PH_MINOR;
                    else if (ph == PH_MINOR) ph = PH_COMPAT;
                end
            end
            PH_MVHD: decode_layout(1'b1);
            PH_TKHD: decode_layout(1'b0);
            default: ;
        endcase
        if (left == 0) begin
            ph = PH_HDR;
            pos = '0;
        end
    endtask

    always @(posedge aclk) begin
        mbsp_out_t want;
        if (!aresetn) begin
            errors = 0;
            records_due.delete();
            restart_parse();
        end else begin
            if (s_valid && s_ready) parse_byte(s_data.data_byte, s_data.file_start);
            if (m_valid && m_ready) begin
                if (records_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected record: id %0d type %h lvl %0d value %h",
                                 m_data.field_id, m_data.box_type, m_data.nest_level,
                                 m_data.field_value);
                end else begin
                    want = records_due.pop_front();
                    if (want.field_id != m_data.field_id || want.box_type != m_data.box_type
                        || want.nest_level != m_data.nest_level
                        || want.field_value != m_data.field_value) begin
                        errors++;
                        if (errors <= 10)
                            $display("record mismatch: expected id %0d type %h lvl %0d value %h, got id %0d type %h lvl %0d value %h",
                                     want.field_id, want.box_type, want.nest_level,
                                     want.field_value, m_data.field_id, m_data.box_type,
                                     m_data.nest_level, m_data.field_value);
                    end
                end
            end
        end
        waiting = records_due.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mbsp_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mbsp_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    mbsp_out_t m_data;
    int        errors;
    int        waiting;

    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_requests;
    int        hold_seen;
    int        hold_cnt;
    int        bytes_sent;
    logic [8:0] file_bytes[$];

    mp4_box_stream_parser_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    mbsp_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .waiting(waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold when requested
    initial begin
        m_ready = 1'b0;
        hold_seen = 0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        logic [8:0] item;
        item = {1'b0, b};
        file_bytes = {file_bytes, item};
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) put_byte(w[i*8 +: 8]);
    endtask

    task automatic put_box(input logic [31:0] size, input logic [31:0] t);
        put_word(size);
        put_word(t);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++) put_byte(8'($urandom));
    endtask

    // mvhd or tkhd with a version byte (if the payload is not empty) and a payload full, short or padded
    task automatic put_layout(input logic [31:0] t);
        int len;
        int full;
        logic [7:0] ver;
        ver = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
        full = (t == T_MVHD) ? ((ver != 0) ? 112 : 100) : ((ver != 0) ? 96 : 84);
        case ($urandom_range(3))
            0: len = $urandom_range(full - 1, 0);
            1: len = full + $urandom_range(6);
            default: len = full;
        endcase
        put_box(len + 8, t);
        if (len > 0) put_byte(ver);
        put_noise((len > 0) ? len - 1 : 0);
    endtask

    task automatic build_file();
        int n;
        int k;
        file_bytes.delete();
        case ($urandom_range(19))
            0: begin
                put_box($urandom_range(7), T_FTYP);
            end
            1: begin
                put_box(8 + 4 * $urandom_range(1) + $urandom_range(3, 1), T_FTYP);
            end
            2: begin
                put_box($urandom_range(40, 8), $urandom);
            end
            default: begin
                k = $urandom_range(3);
                put_box(16 + 4 * k, T_FTYP);
                put_noise(8 + 4 * k);
            end
        endcase
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: put_box($urandom_range(60, 8), T_MOOV);
                1: put_box($urandom_range(60, 8), T_TRAK);
                2, 3: put_layout(T_MVHD);
                4, 5: put_layout(T_TKHD);
                6: begin k = $urandom_range(12); put_box(k + 8, T_MDAT); put_noise(k); end
                7: begin k = $urandom_range(12); put_box(k + 8, T_FREE); put_noise(k); end
                8: begin k = $urandom_range(12); put_box(k + 8, $urandom); put_noise(k); end
                default: begin
                    if ($urandom_range(3) == 0) put_box($urandom_range(7), T_MDAT);
                    else put_box($urandom, $urandom);
                    put_noise($urandom_range(6));
                end
            endcase
        end
        if (file_bytes.size() > 0) file_bytes[0][8] = 1'b1;
    endtask

    task automatic send_byte(input logic [8:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.data_byte <= item[7:0];
        s_data.file_start <= item[8];
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i]);
    endtask

    initial begin
        int drain;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        bytes_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: size zero, non-ftyp first box, misaligned ftyp, minimal ftyp
        file_bytes.delete();
        put_box(32'd0, T_FTYP);
        file_bytes[0][8] = 1'b1;
        send_file();
        file_bytes.delete();
        put_box(32'd16, T_MOOV);
        put_byte(8'hff);
        file_bytes[0][8] = 1'b1;
        send_file();
        file_bytes.delete();
        put_box(32'd18, T_FTYP);
        file_bytes[0][8] = 1'b1;
        send_file();
        file_bytes.delete();
        put_box(32'd16, T_FTYP);
        put_word(32'hffffffff);
        put_word(32'h00000000);
        put_box(32'd8, T_FREE);
        file_bytes[0][8] = 1'b1;
        send_file();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (phase == 0) hold_requests++;
            while (bytes_sent < 450 * (phase + 1)) begin
                build_file();
                send_file();
            end
        end
        s_valid <= 1'b0;

        drain = 0;
        while (waiting != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);
        if (errors == 0 && waiting == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> mp4_box_stream_parser_core.f
src/mbsp_pkg.sv
src/mbsp_parse.sv
src/mbsp_out_reg.sv
src/mp4_box_stream_parser_core.sv
tb/sv/mbsp_checker.sv
tb/sv/testbench.sv
